// ===== rtl/fpa_pkg.sv =====
// Shared types, constants and helpers of the frame period adapter.
package fpa_pkg;

  localparam int WINDOW_LEN   = 100;
  localparam int MAX_LEVELS   = 4;
  localparam int SLOW_TRIGGER = 2;

  localparam int LEVELS_CAP = (MAX_LEVELS < 4) ? MAX_LEVELS : 4;
  localparam int WIN_AW     = $clog2(WINDOW_LEN);
  localparam int CNT_W      = $clog2(WINDOW_LEN + 1);

  localparam int TIME_W = 24;
  localparam int PER_W  = 20;
  localparam int LVL_W  = 2;
  localparam int LCNT_W = 3;
  localparam int CHG_W  = 2;
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 24;

  typedef enum logic [1:0] {
    CLS_EVEN = 2'd0,
    CLS_SLOW = 2'd1,
    CLS_FAST = 2'd2
  } cls_t;

  typedef enum logic [CHG_W-1:0] {
    CHG_NONE   = 2'd0,
    CHG_SLOWER = 2'd1,
    CHG_FASTER = 2'd2
  } chg_t;

  typedef enum logic [CFG_AW-1:0] {
    REG_PERIOD0    = 3'd0,
    REG_PERIOD1    = 3'd1,
    REG_PERIOD2    = 3'd2,
    REG_PERIOD3    = 3'd3,
    REG_LEVEL_CNT  = 3'd4,
    REG_CLOSE_TOL  = 3'd5,
    REG_FAST_MARG  = 3'd6,
    REG_LONG_FRAME = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic             ignored;
    cls_t             cls;
  } cls_res_t;

  typedef struct packed {
    logic              we;
    logic [WIN_AW-1:0] waddr;
    cls_t              wdata;
    logic [WIN_AW-1:0] raddr;
  } win_req_t;

  // Index of the slowest level in use; zero count acts as one.
  function automatic logic [LVL_W-1:0] last_level(input logic [LCNT_W-1:0] lc);
    logic [LCNT_W-1:0] n;
    n = lc;
    if (n == '0) n = LCNT_W'(1);
    if (n > LCNT_W'(LEVELS_CAP)) n = LCNT_W'(LEVELS_CAP);
    return LVL_W'(n - LCNT_W'(1));
  endfunction

endpackage

// ===== rtl/fpa_window_ram.sv =====
// Class window storage: one write port, one registered read port.
module fpa_window_ram (
  input  logic               clk,
  input  fpa_pkg::win_req_t  req,
  output fpa_pkg::cls_t      rd_data
);

  fpa_pkg::cls_t mem [fpa_pkg::WINDOW_LEN];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req.we && (req.waddr == req.raddr)) begin
      rd_data <= req.wdata;
    end else begin
      rd_data <= mem[req.raddr];
    end
  end

endmodule

// ===== rtl/fpa_classify.sv =====
// Frame classifier: long-frame check and close/slow/fast decision.
module fpa_classify (
  input  logic [fpa_pkg::TIME_W-1:0] elapsed,
  input  logic [fpa_pkg::PER_W-1:0]  period_cur,
  input  logic [fpa_pkg::PER_W-1:0]  period_fast,
  input  logic [fpa_pkg::PER_W-1:0]  close_tol,
  input  logic [fpa_pkg::PER_W-1:0]  fast_margin,
  input  logic [fpa_pkg::TIME_W-1:0] long_frame,
  output fpa_pkg::cls_res_t          res
);

  logic [fpa_pkg::TIME_W-1:0] pc_ext;
  logic [fpa_pkg::TIME_W-1:0] gap;
  logic                       above;
  logic [fpa_pkg::PER_W:0]    fast_lim;

  always_comb begin
    pc_ext   = fpa_pkg::TIME_W'(period_cur);
    above    = elapsed > pc_ext;
    gap      = above ? (elapsed - pc_ext) : (pc_ext - elapsed);
    fast_lim = {1'b0, period_fast} + {1'b0, fast_margin};

    res.ignored = elapsed > long_frame;
    if (gap < fpa_pkg::TIME_W'(close_tol)) begin
      res.cls = fpa_pkg::CLS_EVEN;
    end else if (above) begin
      res.cls = fpa_pkg::CLS_SLOW;
    end else if (elapsed < fpa_pkg::TIME_W'(fast_lim)) begin
      res.cls = fpa_pkg::CLS_FAST;
    end else begin
      res.cls = fpa_pkg::CLS_EVEN;
    end
  end

endmodule

// ===== rtl/frame_period_adapter_core.sv =====
// Top level of the frame period adapter: config, window state, result register.
//
//  channel | dir | handshake            | payload
//  in_     | in  | in_tvalid/in_tready  | tdata[23:0] elapsed_us
//  out_    | out | out_tvalid/out_tready| tdata wait/level/period, tuser change/ignored
//  cfg_    | in  | cfg_we               | cfg_addr register index, cfg_wdata value
//
// One word per cycle unless a result waits on out_tready; each result
// appears in the cycle after its word is taken. The window memory is read
// at the next head through its registered port, so the read-modify-write
// of the oldest class closes in the accept cycle. Reset holds in_tready low
// and leaves the window memory unwritten; fill and counts start at zero.
// A result not yet taken holds off input only while out_tready is low.
module frame_period_adapter_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [23:0] elapsed_us
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [19:0] wait_us, [21:20] level, [41:22] period_us, zeros
  output logic [2:0]  out_tuser,  // [1:0] change, [2] ignored
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [23:0] cfg_wdata
);

  localparam int AW = fpa_pkg::WIN_AW;
  localparam int CW = fpa_pkg::CNT_W;
  localparam int LW = fpa_pkg::LVL_W;
  localparam int PW = fpa_pkg::PER_W;

  logic [PW-1:0]                per0_r, per1_r, per2_r, per3_r;
  logic [fpa_pkg::LCNT_W-1:0]   lcnt_r;
  logic [PW-1:0]                tol_r, marg_r;
  logic [fpa_pkg::TIME_W-1:0]   long_r;

  logic [AW-1:0] head_r, head_nxt;
  logic [CW-1:0] fill_r, fill_nxt;
  logic [CW-1:0] slow_r, slow_nxt;
  logic [CW-1:0] fast_r, fast_nxt;
  logic [LW-1:0] level_r, level_nxt;

  logic          out_valid_r;
  logic [PW-1:0] wait_r, per_out_r;
  logic [LW-1:0] lvl_out_r;
  fpa_pkg::chg_t chg_r, chg_nxt;
  logic          ign_r;

  logic                accept;
  logic [LW-1:0]       last_lvl, lvl_c, lvl_f;
  logic [PW-1:0]       pc, pf, p_new, wait_nxt;
  fpa_pkg::cls_res_t   cres;
  fpa_pkg::cls_t       old_cls;
  fpa_pkg::win_req_t   wreq;
  logic                full;
  logic [CW-1:0]       fill_upd, slow_upd, fast_upd;
  logic [AW-1:0]       head_upd;

  function automatic logic [PW-1:0] sel_period(input logic [LW-1:0] idx,
      input logic [PW-1:0] p0, input logic [PW-1:0] p1,
      input logic [PW-1:0] p2, input logic [PW-1:0] p3);
    logic [PW-1:0] p;
    case (idx[1:0])
      2'd0:    p = p0;
      2'd1:    p = p1;
      2'd2:    p = p2;
      2'd3:    p = p3;
      default: p = p0;
    endcase
    return p;
  endfunction

  assign in_tready = rst_n && (!out_valid_r || out_tready);
  assign accept    = in_tvalid && in_tready;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      per0_r <= PW'(50000);
      per1_r <= '0;
      per2_r <= '0;
      per3_r <= '0;
      lcnt_r <= fpa_pkg::LCNT_W'(1);
      tol_r  <= PW'(10000);
      marg_r <= PW'(3000);
      long_r <= fpa_pkg::TIME_W'(600000);
    end else if (cfg_we) begin
      case (fpa_pkg::cfg_idx_t'(cfg_addr))
        fpa_pkg::REG_PERIOD0:    per0_r <= cfg_wdata[PW-1:0];
        fpa_pkg::REG_PERIOD1:    per1_r <= cfg_wdata[PW-1:0];
        fpa_pkg::REG_PERIOD2:    per2_r <= cfg_wdata[PW-1:0];
        fpa_pkg::REG_PERIOD3:    per3_r <= cfg_wdata[PW-1:0];
        fpa_pkg::REG_LEVEL_CNT:  lcnt_r <= cfg_wdata[fpa_pkg::LCNT_W-1:0];
        fpa_pkg::REG_CLOSE_TOL:  tol_r  <= cfg_wdata[PW-1:0];
        fpa_pkg::REG_FAST_MARG:  marg_r <= cfg_wdata[PW-1:0];
        fpa_pkg::REG_LONG_FRAME: long_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // level in use and the periods it selects
  always_comb begin
    last_lvl = fpa_pkg::last_level(lcnt_r);
    lvl_c    = (level_r > last_lvl) ? last_lvl : level_r;
    lvl_f    = (lvl_c != '0) ? (lvl_c - LW'(1)) : '0;
    pc       = sel_period(lvl_c, per0_r, per1_r, per2_r, per3_r);
    pf       = sel_period(lvl_f, per0_r, per1_r, per2_r, per3_r);
  end

  fpa_classify u_classify (
    .elapsed     (in_tdata),
    .period_cur  (pc),
    .period_fast (pf),
    .close_tol   (tol_r),
    .fast_margin (marg_r),
    .long_frame  (long_r),
    .res         (cres)
  );

  fpa_window_ram u_window (
    .clk     (clk),
    .req     (wreq),
    .rd_data (old_cls)
  );

  // window update and level decision
  always_comb begin
    full     = fill_r == CW'(fpa_pkg::WINDOW_LEN);
    fill_upd = full ? fill_r : (fill_r + CW'(1));
    head_upd = head_r;
    if (full) begin
      head_upd = (head_r == AW'(fpa_pkg::WINDOW_LEN - 1)) ? '0 : (head_r + AW'(1));
    end
    slow_upd = slow_r - CW'(full && (old_cls == fpa_pkg::CLS_SLOW))
                      + CW'(cres.cls == fpa_pkg::CLS_SLOW);
    fast_upd = fast_r - CW'(full && (old_cls == fpa_pkg::CLS_FAST))
                      + CW'(cres.cls == fpa_pkg::CLS_FAST);

    head_nxt  = head_r;
    fill_nxt  = fill_r;
    slow_nxt  = slow_r;
    fast_nxt  = fast_r;
    level_nxt = level_r;
    chg_nxt   = fpa_pkg::CHG_NONE;

    wreq.we    = 1'b0;
    wreq.waddr = full ? head_r : fill_r[AW-1:0];
    wreq.wdata = cres.cls;

    if (accept) begin
      level_nxt = lvl_c;
      if (!cres.ignored) begin
        wreq.we  = 1'b1;
        head_nxt = head_upd;
        fill_nxt = fill_upd;
        slow_nxt = slow_upd;
        fast_nxt = fast_upd;
        if (fill_upd == CW'(fpa_pkg::WINDOW_LEN)) begin
          if (slow_upd >= CW'(fpa_pkg::SLOW_TRIGGER)) begin
            if (lvl_c < last_lvl) begin
              level_nxt = lvl_c + LW'(1);
              chg_nxt   = fpa_pkg::CHG_SLOWER;
            end
            head_nxt = '0;
            fill_nxt = '0;
            slow_nxt = '0;
            fast_nxt = '0;
          end else if (fast_upd == CW'(fpa_pkg::WINDOW_LEN)) begin
            if (lvl_c != '0) begin
              level_nxt = lvl_c - LW'(1);
              chg_nxt   = fpa_pkg::CHG_FASTER;
            end
            head_nxt = '0;
            fill_nxt = '0;
            slow_nxt = '0;
            fast_nxt = '0;
          end
        end
      end
    end

    wreq.raddr = head_nxt;

    p_new    = sel_period(level_nxt, per0_r, per1_r, per2_r, per3_r);
    wait_nxt = ((p_new != '0) && (in_tdata < fpa_pkg::TIME_W'(p_new)))
               ? (p_new - in_tdata[PW-1:0]) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      fill_r  <= '0;
      slow_r  <= '0;
      fast_r  <= '0;
      level_r <= '0;
    end else begin
      head_r  <= head_nxt;
      fill_r  <= fill_nxt;
      slow_r  <= slow_nxt;
      fast_r  <= fast_nxt;
      level_r <= level_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      wait_r    <= wait_nxt;
      lvl_out_r <= level_nxt;
      per_out_r <= p_new;
      chg_r     <= chg_nxt;
      ign_r     <= cres.ignored;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, per_out_r, lvl_out_r, wait_r};
  assign out_tuser  = {ign_r, chg_r};

endmodule

// ===== tb/tb_top.sv =====
// Testbench for frame_period_adapter_core: random and directed frame times, checked per word.
module tb_top;
  import fpa_pkg::*;

  typedef struct packed {
    logic [PER_W-1:0] wait_us;
    logic [LVL_W-1:0] level;
    logic [PER_W-1:0] period_us;
    chg_t             change;
    logic             ignored;
  } pace_res_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;   // [19:0] wait_us, [21:20] level, [41:22] period_us, zeros
  logic [2:0]  out_tuser;   // [1:0] change, [2] ignored
  logic        cfg_we = 1'b0;
  cfg_idx_t    cfg_addr = REG_PERIOD0;
  logic [23:0] cfg_wdata = '0;

  frame_period_adapter_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  // predictor copy of the registers
  logic [PER_W-1:0]  cfg_period [4] = '{20'd50000, 20'd0, 20'd0, 20'd0};
  logic [LCNT_W-1:0] cfg_lcount = 3'd1;
  logic [PER_W-1:0]  cfg_tol_us = 20'd10000;
  logic [PER_W-1:0]  cfg_margin_us = 20'd3000;
  logic [TIME_W-1:0] cfg_long_us = 24'd600000;

  // predictor state
  cls_t        cls_win [WINDOW_LEN];
  int unsigned win_head = 0;
  int unsigned win_fill = 0;
  int unsigned n_slow = 0;
  int unsigned n_fast = 0;
  int unsigned cur_level = 0;

  logic [TIME_W-1:0] frame_q [$];
  pace_res_t         paced_q [$];
  bit                frame_taken = 1'b0;
  int unsigned       tx_idle_pct = 0;
  int unsigned       rx_stall_pct = 0;
  int unsigned       mismatch_cnt = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #8000000;
    $display("Regression FAIL");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [47:0] got,
                                 input logic [47:0] want);
    $display("%0t mismatch %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    mismatch_cnt++;
  endtask

  task automatic queue_frame(input logic [TIME_W-1:0] x);
    frame_q = {frame_q, x};
  endtask

  task automatic pace_frame(input logic [TIME_W-1:0] e);
    pace_res_t   r;
    int unsigned n_lvl, pc, pf, gap, p;
    cls_t        c, old;
    n_lvl = 32'(cfg_lcount);
    if (n_lvl == 0) n_lvl = 1;
    if (n_lvl > 4) n_lvl = 4;
    if (n_lvl > MAX_LEVELS) n_lvl = MAX_LEVELS;
    if (cur_level > n_lvl - 1) cur_level = n_lvl - 1;
    r.change = CHG_NONE;
    r.ignored = 1'b0;
    if (e > cfg_long_us) begin
      r.ignored = 1'b1;
    end else begin
      pc = 32'(cfg_period[cur_level]);
      pf = 32'(cfg_period[(cur_level > 0) ? cur_level - 1 : 0]);
      gap = (32'(e) > pc) ? 32'(e) - pc : pc - 32'(e);
      if (gap < 32'(cfg_tol_us)) c = CLS_EVEN;
      else if (32'(e) > pc) c = CLS_SLOW;
      else if (32'(e) < pf + 32'(cfg_margin_us)) c = CLS_FAST;
      else c = CLS_EVEN;
      if (win_fill >= WINDOW_LEN) begin
        old = cls_win[win_head];
        if (old == CLS_SLOW) n_slow--;
        else if (old == CLS_FAST) n_fast--;
        cls_win[win_head] = c;
        win_head = (win_head + 1) % WINDOW_LEN;
      end else begin
        cls_win[(win_head + win_fill) % WINDOW_LEN] = c;
        win_fill++;
      end
      if (c == CLS_SLOW) n_slow++;
      else if (c == CLS_FAST) n_fast++;
      if (win_fill == WINDOW_LEN) begin
        if (n_slow >= SLOW_TRIGGER) begin
          if (cur_level < n_lvl - 1) begin
            cur_level++;
            r.change = CHG_SLOWER;
          end
          win_head = 0; win_fill = 0; n_slow = 0; n_fast = 0;
        end else if (n_slow == 0 && n_fast == win_fill) begin
          if (cur_level > 0) begin
            cur_level--;
            r.change = CHG_FASTER;
          end
          win_head = 0; win_fill = 0; n_slow = 0; n_fast = 0;
        end
      end
    end
    p = 32'(cfg_period[cur_level]);
    r.wait_us = (p != 0 && 32'(e) < p) ? PER_W'(p - 32'(e)) : '0;
    r.level = LVL_W'(cur_level);
    r.period_us = PER_W'(p);
    paced_q = {paced_q, r};
  endtask

  // result check first, then the word taken at the same edge
  always @(posedge clk) begin : mon
    pace_res_t w;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (paced_q.size() == 0) begin
          report_mismatch("unexpected word", out_tdata, '0);
        end else begin
          w = paced_q[0];
          paced_q.delete(0);
          if (out_tdata[19:0] !== w.wait_us)
            report_mismatch("wait_us", 48'(out_tdata[19:0]), 48'(w.wait_us));
          if (out_tdata[21:20] !== w.level)
            report_mismatch("level", 48'(out_tdata[21:20]), 48'(w.level));
          if (out_tdata[41:22] !== w.period_us)
            report_mismatch("period_us", 48'(out_tdata[41:22]), 48'(w.period_us));
          if (out_tdata[47:42] !== '0)
            report_mismatch("tdata pad", 48'(out_tdata[47:42]), '0);
          if (out_tuser[1:0] !== w.change)
            report_mismatch("change", 48'(out_tuser[1:0]), 48'(w.change));
          if (out_tuser[2] !== w.ignored)
            report_mismatch("ignored", 48'(out_tuser[2]), 48'(w.ignored));
        end
      end
      frame_taken = in_tvalid && in_tready;
      if (frame_taken) pace_frame(in_tdata);
    end
  end

  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_tvalid || frame_taken) begin
        if (frame_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          in_tvalid <= 1'b1;
          in_tdata <= frame_q[0];
          frame_q.delete(0);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
      out_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  task automatic cfg_write(input cfg_idx_t idx, input int unsigned val);
    logic [23:0] bus;
    bus = val[23:0];
    case (idx)
      REG_LEVEL_CNT: begin
        bus[23:3] = 21'($urandom);
        cfg_lcount = val[2:0];
      end
      REG_CLOSE_TOL: begin
        bus[23:20] = 4'($urandom);
        cfg_tol_us = val[19:0];
      end
      REG_FAST_MARG: begin
        bus[23:20] = 4'($urandom);
        cfg_margin_us = val[19:0];
      end
      REG_LONG_FRAME: begin
        cfg_long_us = val[23:0];
      end
      default: begin
        bus[23:20] = 4'($urandom);
        cfg_period[idx[1:0]] = val[19:0];
      end
    endcase
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= bus;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_all(input int unsigned p0, p1, p2, p3, cnt, tol, marg, lng);
    cfg_write(REG_PERIOD0, p0);
    cfg_write(REG_PERIOD1, p1);
    cfg_write(REG_PERIOD2, p2);
    cfg_write(REG_PERIOD3, p3);
    cfg_write(REG_LEVEL_CNT, cnt);
    cfg_write(REG_CLOSE_TOL, tol);
    cfg_write(REG_FAST_MARG, marg);
    cfg_write(REG_LONG_FRAME, lng);
  endtask

  function automatic logic [TIME_W-1:0] long_word();
    if (cfg_long_us == 24'hFFFFFF) return 24'hFFFFFF;
    return TIME_W'($urandom_range(24'hFFFFFF, cfg_long_us + 1));
  endfunction

  // runs of fast words walk the level down; runs with a few slow words walk it up
  task automatic fill_random(input int unsigned n, fmax, smin, smax);
    int unsigned made, len, k, sel;
    logic [TIME_W-1:0] w;
    made = 0;
    while (made < n) begin
      sel = $urandom_range(99);
      if (sel < 45) begin
        len = 100 + $urandom_range(8);
        for (k = 0; k < len; k++) begin
          if ($urandom_range(99) < 3) queue_frame(long_word());
          else queue_frame(TIME_W'($urandom_range(fmax)));
        end
      end else if (sel < 80) begin
        len = 100;
        for (k = 0; k < len; k++) begin
          if ($urandom_range(99) < 3) queue_frame(TIME_W'($urandom_range(smax, smin)));
          else queue_frame(TIME_W'($urandom_range(fmax)));
        end
      end else begin
        len = 10 + $urandom_range(20);
        for (k = 0; k < len; k++) begin
          case ($urandom_range(4))
            0: w = TIME_W'($urandom_range(cfg_long_us));
            1: w = TIME_W'($urandom);
            2: w = long_word();
            3: w = TIME_W'(cfg_period[$urandom_range(3)] + $urandom_range(2 * cfg_tol_us)
                           - cfg_tol_us);
            default: w = cfg_long_us;
          endcase
          queue_frame(w);
        end
      end
      made += len;
    end
  endtask

  task automatic drain();
    while (frame_q.size() != 0 || in_tvalid || paced_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset settings: one level of 50000, tolerance 10000, long limit 600000
    frame_q = '{24'd0, 24'hFFFFFF, 24'd600000, 24'd600001, 24'd50000, 24'd40001,
                24'd40000, 24'd60000, 24'd59999, 24'hAAAAAA, 24'h555555, 24'h0AAAAA,
                24'h055555};
    drain();

    set_all(10000, 20000, 30000, 40000, 4, 2000, 1000, 100000);
    fill_random(130, 7000, 42001, 100000);
    drain();

    tx_idle_pct = 82;
    cfg_write(REG_LEVEL_CNT, 2);
    cfg_write(REG_CLOSE_TOL, 0);
    cfg_write(REG_FAST_MARG, 0);
    fill_random(100, 9999, 40001, 100000);
    drain();

    tx_idle_pct = 0;
    rx_stall_pct = 82;
    set_all(0, 1000000, 300000, 1000000, 7, 1000000, 1000000, 16777215);
    fill_random(100, 0, 2000000, 16777215);
    drain();

    tx_idle_pct = 36;
    rx_stall_pct = 36;
    set_all(1, 2, 3, 4, 3, 1, 1, 0);
    fill_random(40, 0, 1, 100);
    drain();

    set_all(16000, 33000, 50000, 66000, 4, 3000, 2000, 600000);
    fill_random(110, 12000, 69001, 600000);
    drain();

    tx_idle_pct = 82;
    rx_stall_pct = 0;
    cfg_write(REG_LEVEL_CNT, 0);
    fill_random(80, 12000, 69001, 600000);
    drain();

    tx_idle_pct = 0;
    rx_stall_pct = 82;
    cfg_write(REG_LEVEL_CNT, 4);
    fill_random(80, 12000, 69001, 600000);
    drain();

    if (mismatch_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/fpa_pkg.sv
rtl/fpa_window_ram.sv
rtl/fpa_classify.sv
rtl/frame_period_adapter_core.sv
tb/tb_top.sv
